// ===== rtl/mtf_pkg.sv =====
`timescale 1ns / 1ps
// Move-to-front encoder package: shared widths, reset values, register map
// and the control struct that travels along the cell chain. No dependencies.
package mtf_pkg;

	localparam int MAX_SYMBOLS_DEF = 256;

	localparam int SYM_W   = 9;   // symbol port / list_size width
	localparam int INDEX_W = 8;   // index port width
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [SYM_W-1:0] LIST_SIZE_RST = 9'd256;

	// register index = paddr[2]
	localparam logic REG_LIST_SIZE = 1'b0;

	typedef struct packed {
		logic valid;    // beat present in this stage
		logic restart;  // restore ascending order ahead of this beat
		logic oor;      // symbol out of range, list untouched but for a restart
		logic found;    // symbol already matched upstream
	} mtf_ctl_t;

endpackage

// ===== rtl/mtf_cell.sv =====
`timescale 1ns / 1ps
// One list position of the move-to-front chain: holds the symbol at that
// position and passes each beat to the next cell. Uses mtf_pkg.
module mtf_cell #(
	parameter int SW  = 9,
	parameter int IW  = 8,
	parameter int POS = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  mtf_pkg::mtf_ctl_t ctl_in,
	input  logic [SW-1:0]     query_in,
	input  logic [SW-1:0]     carry_in,
	input  logic [IW-1:0]     index_in,
	output mtf_pkg::mtf_ctl_t ctl_out,
	output logic [SW-1:0]     query_out,
	output logic [SW-1:0]     carry_out,
	output logic [IW-1:0]     index_out,
	output logic [SW-1:0]     sym
);

	localparam logic [SW-1:0] POS_SYM = SW'(POS + 1);
	localparam logic [IW-1:0] POS_IDX = IW'(POS);

	logic [SW-1:0]     sym_q, sym_d, base;
	mtf_pkg::mtf_ctl_t ctl_s1, ctl_d;
	logic [SW-1:0]     query_s1, carry_s1, carry_d;
	logic [IW-1:0]     index_s1, index_d;

	assign base = ctl_in.restart ? POS_SYM : sym_q;

	// Until the match, every cell takes the symbol displaced from the cell
	// before it; the matching cell takes it and the rest stay put.
	always_comb begin
		sym_d   = sym_q;
		ctl_d   = ctl_in;
		carry_d = carry_in;
		index_d = index_in;
		if (ctl_in.valid) begin
			sym_d = base;
			if (!ctl_in.oor && !ctl_in.found) begin
				sym_d = carry_in;
				if (base == query_in) begin
					ctl_d.found = 1'b1;
					index_d     = POS_IDX;
				end else begin
					carry_d = base;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q  <= POS_SYM;
			ctl_s1 <= '0;
		end else if (adv) begin
			sym_q  <= sym_d;
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			query_s1 <= query_in;
			carry_s1 <= carry_d;
			index_s1 <= index_d;
		end
	end

	assign ctl_out   = ctl_s1;
	assign query_out = query_s1;
	assign carry_out = carry_s1;
	assign index_out = index_s1;
	assign sym       = sym_q;

endmodule

// ===== rtl/move_to_front_encoder_top.sv =====
`timescale 1ns / 1ps
// Move-to-front encoder, one list position per cell in a chain of MAX_SYMBOLS.
// Each beat passes through the stage register of every cell in turn; the
// last cell's register holds the result. Throughput: one beat per cycle,
// unless a result held by out_ready low stalls the whole chain.
// Reset: list ascending (symbol s at position s-1), list_size = 256, chain
// empty. Depends on mtf_pkg and mtf_cell.
module move_to_front_encoder_top #(
	parameter int MAX_SYMBOLS = mtf_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mtf_pkg::SYM_W-1:0]    symbol,
	input  logic                         restart,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mtf_pkg::INDEX_W-1:0]  index,
	output logic                         out_of_range,
	// APB configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mtf_pkg::PADDR_W-1:0]  paddr,
	input  logic [mtf_pkg::PDATA_W-1:0]  pwdata,
	output logic [mtf_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	// Symbols 1..MAX_SYMBOLS live in the cells; positions 0..MAX_SYMBOLS-1.
	localparam int SW = $clog2(MAX_SYMBOLS + 1);
	localparam int IW = $clog2(MAX_SYMBOLS);
	// compare width wide enough for both the port symbol and the clamp
	localparam int CW = (SW > mtf_pkg::SYM_W) ? SW : mtf_pkg::SYM_W;
	localparam logic [CW-1:0] MAX_CW = CW'(MAX_SYMBOLS);

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [mtf_pkg::SYM_W-1:0] list_size_q;
	logic                      reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == mtf_pkg::REG_LIST_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_size_q <= mtf_pkg::LIST_SIZE_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			list_size_q <= pwdata[mtf_pkg::SYM_W-1:0];
		end
	end

	assign prdata = reg_sel ? mtf_pkg::PDATA_W'(list_size_q) : '0;

	// ---------------------------------------------------------------
	// Range check at the chain entry. A size of 0 acts as 1, a size above
	// MAX_SYMBOLS as MAX_SYMBOLS. The user must change list_size only while
	// idle, which the block does not enforce; then entry and turn checks agree.
	// ---------------------------------------------------------------
	logic [CW-1:0] size_cw, eff_size, sym_cw;
	logic          sym_oor;

	always_comb begin
		size_cw = CW'(list_size_q);
		sym_cw  = CW'(symbol);
		if (size_cw == '0) begin
			eff_size = CW'(1);
		end else if (size_cw > MAX_CW) begin
			eff_size = MAX_CW;
		end else begin
			eff_size = size_cw;
		end
		sym_oor = (sym_cw == '0) || (sym_cw > eff_size);
	end

	// ---------------------------------------------------------------
	// Cell chain. The whole chain moves together; the last cell's stage
	// register is the result register, so a new beat enters whenever the
	// result is empty or being taken.
	// ---------------------------------------------------------------
	logic adv;

	mtf_pkg::mtf_ctl_t ctl_c   [0:MAX_SYMBOLS];
	logic [SW-1:0]     query_c [0:MAX_SYMBOLS];
	logic [SW-1:0]     carry_c [0:MAX_SYMBOLS];
	logic [IW-1:0]     index_c [0:MAX_SYMBOLS];
	logic [SW-1:0]     cell_sym[0:MAX_SYMBOLS-1];

	assign adv      = !ctl_c[MAX_SYMBOLS].valid || out_ready;
	assign in_ready = adv;

	// front cell: the queried symbol is what lands at position 0
	always_comb begin
		ctl_c[0].valid   = in_valid && adv;
		ctl_c[0].restart = restart;
		ctl_c[0].oor     = sym_oor;
		ctl_c[0].found   = 1'b0;
		query_c[0]       = SW'(symbol);
		carry_c[0]       = SW'(symbol);
		index_c[0]       = '0;
	end

	for (genvar g = 0; g < MAX_SYMBOLS; g++) begin : g_cell
		mtf_cell #(
			.SW  (SW),
			.IW  (IW),
			.POS (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.ctl_in    (ctl_c[g]),
			.query_in  (query_c[g]),
			.carry_in  (carry_c[g]),
			.index_in  (index_c[g]),
			.ctl_out   (ctl_c[g+1]),
			.query_out (query_c[g+1]),
			.carry_out (carry_c[g+1]),
			.index_out (index_c[g+1]),
			.sym       (cell_sym[g])
		);
	end

	// ---------------------------------------------------------------
	// Result beat; index wraps to 8 bits for larger lists
	// ---------------------------------------------------------------
	assign out_valid    = ctl_c[MAX_SYMBOLS].valid;
	assign out_of_range = ctl_c[MAX_SYMBOLS].oor;
	assign index        = ctl_c[MAX_SYMBOLS].oor ? '0
	                      : mtf_pkg::INDEX_W'(index_c[MAX_SYMBOLS]);

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// an in-range symbol always meets its own cell somewhere in the chain
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[MAX_SYMBOLS].valid && !ctl_c[MAX_SYMBOLS].oor |->
		ctl_c[MAX_SYMBOLS].found)
		else $error("in-range beat left the chain unmatched");

	// an out-of-range beat never matches; it moves the list only on a restart
	a_oor_nofind: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[MAX_SYMBOLS].valid && ctl_c[MAX_SYMBOLS].oor |->
		!ctl_c[MAX_SYMBOLS].found)
		else $error("out-of-range beat matched a cell");

	// an accepted in-range symbol is at the front in the cycle after it is taken
	a_front: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !sym_oor |=> cell_sym[0] == $past(SW'(symbol)))
		else $error("front cell does not hold the last symbol");

	// an accepted restart with a bad symbol puts symbol 1 at the front
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && restart && sym_oor |=> cell_sym[0] == SW'(1))
		else $error("restart did not restore the front cell");

endmodule
